// File: hw/rtl/wma_pkg.sv
// Shared constants, types and codes for the windowed momentum alert block.
package wma_pkg;

  localparam int SYMBOLS    = 64;
  localparam int RING_DEPTH = 256;
  localparam int MIN_TICKS  = 3;

  localparam int SYM_AW  = $clog2(SYMBOLS);
  localparam int HEAD_W  = $clog2(RING_DEPTH);
  localparam int CNT_W   = HEAD_W + 1;
  localparam int RING_AW = SYM_AW + HEAD_W;
  localparam int META_W  = 32 + CNT_W + HEAD_W;

  localparam int QBITS = 15;
  localparam int NUM_W = 46;

  localparam logic [13:0] THR_RESET = 14'd100;
  localparam logic [16:0] WIN_RESET = 17'd600;
  localparam logic [16:0] DEB_RESET = 17'd900;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd2;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_RISE     = 3'd1;
  localparam logic [2:0] ST_FALL     = 3'd2;
  localparam logic [2:0] ST_REJECT   = 3'd3;
  localparam logic [2:0] ST_FEW      = 3'd4;
  localparam logic [2:0] ST_DEBOUNCE = 3'd5;

  typedef struct packed {
    logic latch;
    logic reject;
    logic append;
    logic ev_adv;
    logic cap_old;
    logic few;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic fin;
    logic meta_we;
  } wma_cmd_t;

  typedef struct packed {
    logic bad;
    logic cnt_zero;
    logic stale;
    logic few;
    logic div_last;
  } wma_sts_t;

endpackage

// File: hw/rtl/wma_ram.sv
// Generic single-port-write, registered-read RAM.
module wma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/wma_ctrl.sv
// Controller state machine sequencing one tick through the datapath.
module wma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  wma_pkg::wma_sts_t sts,
  output wma_pkg::wma_cmd_t cmd
);
  import wma_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_META   = 4'd1;
  localparam logic [3:0] S_APPEND = 4'd2;
  localparam logic [3:0] S_EVRD   = 4'd3;
  localparam logic [3:0] S_EVCMP  = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_DIV0   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = S_META;
        end
      end
      S_META: state_next = S_APPEND;
      S_APPEND: begin
        if (sts.bad) begin
          cmd.reject = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.append = 1'b1;
          state_next = S_EVRD;
        end
      end
      S_EVRD: state_next = sts.cnt_zero ? S_CHK : S_EVCMP;
      S_EVCMP: begin
        if (sts.stale) begin
          cmd.ev_adv = 1'b1;
          state_next = S_EVRD;
        end else begin
          cmd.cap_old = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.few) begin
          cmd.few = 1'b1;
          cmd.meta_we = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_DIV0;
      end
      S_DIV0: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        cmd.meta_we = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after result strobe");
  a_one_meta_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.meta_we |=> done) else $error("state write not followed by result");
  a_no_append_reject: assert property (@(posedge clk) disable iff (rst)
    !(cmd.append && cmd.reject)) else $error("append on rejected request");
`endif

endmodule

// File: hw/rtl/wma_dp.sv
// Datapath: tick rings, per-symbol state, eviction compare, move divider.
module wma_dp (
  input  logic              clk,
  input  logic              rst,
  input  wma_pkg::wma_cmd_t cmd,
  output wma_pkg::wma_sts_t sts,
  input  logic [5:0]        symbol_index,
  input  logic [31:0]       price,
  input  logic [31:0]       timestamp_s,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic [5:0]        symbol_echo,
  output logic [2:0]        status,
  output logic [15:0]       move_hundredths,
  output logic [8:0]        window_count
);
  import wma_pkg::*;

  logic [13:0] thr;
  logic [16:0] win;
  logic [16:0] deb;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      win <= WIN_RESET;
      deb <= DEB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr <= cfg_data[13:0];
        REG_WINDOW:    win <= cfg_data[16:0];
        REG_DEBOUNCE:  deb <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [5:0]  sym_r;
  logic [31:0] px_r;
  logic [31:0] ts_r;
  logic [HEAD_W-1:0] head_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0] last_r;
  logic [31:0] old_r;
  logic        neg;
  logic [31:0] diff;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] tq;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dreg;
  logic [QBITS-1:0] q;
  logic [3:0]  step;
  logic        sat;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_r <= symbol_index;
      px_r  <= price;
      ts_r  <= timestamp_s;
    end
  end

  logic sym_bad;
  assign sym_bad = ({1'b0, sym_r} >= 7'(SYMBOLS));

  // per-symbol state: {last alert time, count, head}, zero until first written
  logic [SYMBOLS-1:0] meta_vld;
  logic               meta_vld_q;
  logic [META_W-1:0]  meta_rdata;
  logic [META_W-1:0]  meta_wdata;
  logic [SYM_AW-1:0]  meta_addr;
  logic [HEAD_W-1:0]  head_m;
  logic [CNT_W-1:0]   cnt_m;
  logic [31:0]        last_m;
  logic [31:0]        last_new;

  assign meta_addr = sym_r[SYM_AW-1:0];

  wma_ram #(.WIDTH(META_W), .DEPTH(SYMBOLS)) u_meta (
    .clk(clk), .we(cmd.meta_we), .waddr(meta_addr), .wdata(meta_wdata),
    .raddr(meta_addr), .rdata(meta_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld <= '0;
    end else if (cmd.meta_we) begin
      meta_vld[meta_addr] <= 1'b1;
    end
    meta_vld_q <= meta_vld[meta_addr];
  end

  assign head_m = meta_vld_q ? meta_rdata[HEAD_W-1:0] : '0;
  assign cnt_m  = meta_vld_q ? meta_rdata[HEAD_W +: CNT_W] : '0;
  assign last_m = meta_vld_q ? meta_rdata[META_W-1 -: 32] : '0;

  // ring of {time, price} per symbol
  logic [HEAD_W-1:0]  pos;
  logic [CNT_W-1:0]   hsum;
  logic [63:0]        ring_rdata;
  logic [31:0]        rt;
  logic [31:0]        rp;

  assign hsum = {1'b0, head_m} + cnt_m;
  assign pos  = (cnt_m >= CNT_W'(RING_DEPTH)) ? head_m :
                (hsum >= CNT_W'(RING_DEPTH)) ? HEAD_W'(hsum - CNT_W'(RING_DEPTH)) :
                HEAD_W'(hsum);

  wma_ram #(.WIDTH(64), .DEPTH(SYMBOLS * RING_DEPTH)) u_ring (
    .clk(clk), .we(cmd.append), .waddr({meta_addr, pos}), .wdata({ts_r, px_r}),
    .raddr({meta_addr, head_r}), .rdata(ring_rdata)
  );

  assign rt = ring_rdata[63:32];
  assign rp = ring_rdata[31:0];

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    head_inc = (h == HEAD_W'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      last_r <= last_m;
      if (cnt_m >= CNT_W'(RING_DEPTH)) begin
        head_r <= head_inc(head_m);
        cnt_r  <= CNT_W'(RING_DEPTH);
      end else begin
        head_r <= head_m;
        cnt_r  <= cnt_m + 1'b1;
      end
    end else if (cmd.ev_adv) begin
      head_r <= head_inc(head_r);
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.cap_old) begin
      old_r <= (rp == 32'd0) ? 32'd1 : rp;
    end
    if (cmd.mul1) begin
      neg  <= (px_r < old_r);
      diff <= (px_r < old_r) ? old_r - px_r : px_r - old_r;
    end
    if (cmd.mul2) begin
      num <= {14'd0, diff} * NUM_W'(10000);
      tq  <= {32'd0, thr} * {14'd0, old_r};
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_init) begin
      sat  <= ({1'b0, num} >= {old_r, 15'd0});
      rem  <= num;
      dreg <= {old_r, 14'd0};
      q    <= '0;
      step <= 4'(QBITS - 1);
    end else if (cmd.div_step) begin
      if (rem >= dreg) begin
        rem <= rem - dreg;
        q   <= {q[QBITS-2:0], 1'b1};
      end else begin
        q   <= {q[QBITS-2:0], 1'b0};
      end
      dreg <= dreg >> 1;
      step <= step - 1'b1;
    end
  end

  logic               alert;
  logic               debounced;
  logic signed [33:0] since;

  assign alert     = (num >= tq);
  assign since     = $signed({2'b00, ts_r}) - $signed({2'b00, last_r});
  assign debounced = (since < $signed({17'd0, deb}));
  assign last_new  = (cmd.fin && alert && !debounced) ? ts_r : last_r;
  assign meta_wdata = {last_new, cnt_r, head_r};

  assign sts.bad      = sym_bad || (px_r == 32'd0);
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.stale    = ({1'b0, rt} + {16'd0, win}) < {1'b0, ts_r};
  assign sts.few      = (cnt_r < CNT_W'(MIN_TICKS));
  assign sts.div_last = (step == 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      symbol_echo     <= sym_r;
      status          <= ST_REJECT;
      move_hundredths <= '0;
      window_count    <= sym_bad ? 9'd0 : 9'(cnt_m);
    end else if (cmd.few) begin
      symbol_echo     <= sym_r;
      status          <= ST_FEW;
      move_hundredths <= '0;
      window_count    <= 9'(cnt_r);
    end else if (cmd.fin) begin
      symbol_echo  <= sym_r;
      window_count <= 9'(cnt_r);
      if (neg) begin
        move_hundredths <= 16'(-$signed({1'b0, q}));
      end else begin
        move_hundredths <= sat ? 16'sd32767 : {1'b0, q};
      end
      if (!alert) begin
        status <= ST_NONE;
      end else if (debounced) begin
        status <= ST_DEBOUNCE;
      end else begin
        status <= (!neg && diff != 32'd0) ? ST_RISE : ST_FALL;
      end
    end
  end

endmodule

// File: hw/rtl/windowed_momentum_alert_top.sv
// Top level of the windowed momentum alert block.
// A tick is taken when start is high and busy is low; its single result shows
// on the result ports for one cycle with done high and must be captured then,
// since the block cannot be held off. A rejected tick (zero price) reports
// straight after its per-symbol state read. Otherwise k stale ticks are evicted,
// each taking one read and one compare on the tick ring memory: a tick left
// with fewer than three held ticks reports after the evictions; a full check
// then forms the difference and products and runs a 15-step restoring divider
// for the move value. busy stays high through the done cycle, so the next tick
// is taken the cycle after it at the earliest. State reads as zero after
// reset with no clearing pass; the configuration port is always ready and
// should be written while busy is low.
module windowed_momentum_alert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  symbol_index,
  input  logic [31:0] price,
  input  logic [31:0] timestamp_s,
  output logic        done,
  output logic [5:0]  symbol_echo,
  output logic [2:0]  status,
  output logic [15:0] move_hundredths,
  output logic [8:0]  window_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import wma_pkg::*;

  wma_cmd_t cmd;
  wma_sts_t sts;

  assign cfg_ready = 1'b1;

  wma_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .sts(sts), .cmd(cmd)
  );

  wma_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .symbol_index(symbol_index), .price(price), .timestamp_s(timestamp_s),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .symbol_echo(symbol_echo), .status(status),
    .move_hundredths(move_hundredths), .window_count(window_count)
  );

endmodule
